@@ rtl/gbte_pkg.sv @@
// gbte_pkg: shared constants, command codes and control/status structs
// for the gap buffer text engine; no dependencies
package gbte_pkg;

	localparam int CAPACITY = 1024;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int POS_W    = 11;
	localparam int CHAR_W   = 8;
	localparam int CMD_W    = 3;

	localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LEFT   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RIGHT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SETCUR = 3'd3;
	localparam logic [CMD_W-1:0] CMD_BKSP   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DEL    = 3'd5;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd6;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic exec;
		logic move;
		logic ld_out;
	} gbte_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic is_move;
		logic at_target;
	} gbte_sts_t;

endpackage

@@ rtl/gap_buffer_text_engine_unit.sv @@
// gap_buffer_text_engine_unit: top level of the gap buffer text engine
// instantiates gbte_ctrl and gbte_dp; uses gbte_pkg
//
// usage:
// - input channel (in_valid/in_stall) carries one command beat: cmd, char_in
//   and operand; a beat is taken when in_valid is high and in_stall low
// - output channel (out_valid/out_stall) gives one result beat per command:
//   ok, char_out, cursor_pos, used_len
// - one command is worked on at a time; in_stall stays high until its result
//   has moved into the output register
// - insert, backspace, delete, read and unused codes: execute state, then the
//   result is registered from the done state and the next beat taken in idle
// - left, right and set cursor move bytes across the gap through the single
//   memory port pair, one byte per cycle; the result is registered once the
//   cursor reaches its target and the next beat is taken after that
// - the output register holds a finished result while out_stall is high; the
//   next command is taken meanwhile, and its result waits until the register
//   empties
// - reset empties the text (cursor 0, gap end at capacity); the text memory is
//   not cleared and no location is read before it is written
module gap_buffer_text_engine_unit import gbte_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [CHAR_W-1:0] char_in,
	input  logic [POS_W-1:0]  operand,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              ok,
	output logic [CHAR_W-1:0] char_out,
	output logic [POS_W-1:0]  cursor_pos,
	output logic [POS_W-1:0]  used_len
);

	gbte_ctl_t ctl;
	gbte_sts_t sts;

	gbte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	gbte_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.cmd        (cmd),
		.char_in    (char_in),
		.operand    (operand),
		.ok         (ok),
		.char_out   (char_out),
		.cursor_pos (cursor_pos),
		.used_len   (used_len)
	);

endmodule

@@ rtl/gbte_dp.sv @@
// gbte_dp: datapath of the gap buffer engine: text memory, cursor and gap
// registers, move pipeline and result register; uses gbte_pkg
module gbte_dp import gbte_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  gbte_ctl_t         ctl,
	output gbte_sts_t         sts,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [CHAR_W-1:0] char_in,
	input  logic [POS_W-1:0]  operand,
	output logic              ok,
	output logic [CHAR_W-1:0] char_out,
	output logic [POS_W-1:0]  cursor_pos,
	output logic [POS_W-1:0]  used_len
);

	logic [CHAR_W-1:0] mem [CAPACITY];

	logic [CMD_W-1:0]  cmd_q;
	logic [CHAR_W-1:0] char_q;
	logic [POS_W-1:0]  opnd_q;
	logic [POS_W-1:0]  cursor_q, gap_q, target_q;
	logic              ok_q, rd_hit_q;
	logic [CHAR_W-1:0] rdata_q;
	logic              pend_s1;
	logic [ADDR_W-1:0] dest_s1;
	logic              ok_o_q;
	logic [CHAR_W-1:0] char_o_q;
	logic [POS_W-1:0]  cur_o_q, used_o_q;

	logic [POS_W-1:0]  used, back, phys, cursor_d, gap_d, target_d;
	logic              ok_d, rd_hit_d, step, go_right;
	logic              wr_en, rd_en;
	logic [ADDR_W-1:0] wr_addr, rd_addr, dest_d;
	logic [CHAR_W-1:0] wr_data;

	assign used     = cursor_q + (CAP_POS - gap_q);
	assign back     = CAP_POS - gap_q;
	assign phys     = (opnd_q < cursor_q) ? opnd_q : opnd_q + gap_q - cursor_q;
	assign step     = cursor_q != target_q;
	assign go_right = cursor_q < target_q;

	assign sts.is_move   = (cmd_q == CMD_LEFT) || (cmd_q == CMD_RIGHT) || (cmd_q == CMD_SETCUR);
	assign sts.at_target = !step;

	always_comb begin
		cursor_d = cursor_q;
		gap_d    = gap_q;
		target_d = target_q;
		ok_d     = ok_q;
		rd_hit_d = rd_hit_q;
		dest_d   = dest_s1;
		wr_en    = 1'b0;
		wr_addr  = dest_s1;
		wr_data  = rdata_q;
		rd_en    = 1'b0;
		rd_addr  = phys[ADDR_W-1:0];
		if (ctl.exec) begin
			ok_d     = 1'b1;
			rd_hit_d = 1'b0;
			target_d = cursor_q;
			case (cmd_q)
				CMD_INSERT: begin
					if (cursor_q < gap_q) begin
						wr_en    = 1'b1;
						wr_addr  = cursor_q[ADDR_W-1:0];
						wr_data  = char_q;
						cursor_d = cursor_q + 1'b1;
					end else begin
						ok_d = 1'b0;
					end
				end
				CMD_LEFT: begin
					if (cursor_q != '0) target_d = cursor_q - 1'b1;
				end
				CMD_RIGHT: begin
					if (back != '0) target_d = cursor_q + 1'b1;
				end
				CMD_SETCUR: target_d = (opnd_q > used) ? used : opnd_q;
				CMD_BKSP:   cursor_d = cursor_q - ((opnd_q > cursor_q) ? cursor_q : opnd_q);
				CMD_DEL:    gap_d = gap_q + ((opnd_q > back) ? back : opnd_q);
				CMD_READ: begin
					if (opnd_q < used) begin
						rd_en    = 1'b1;
						rd_hit_d = 1'b1;
					end
				end
				default: ;
			endcase
		end
		if (ctl.move) begin
			// the byte fetched last cycle lands on the other side of the gap
			wr_en = pend_s1;
			if (step) begin
				rd_en = 1'b1;
				if (go_right) begin
					rd_addr  = gap_q[ADDR_W-1:0];
					dest_d   = cursor_q[ADDR_W-1:0];
					cursor_d = cursor_q + 1'b1;
					gap_d    = gap_q + 1'b1;
				end else begin
					rd_addr  = ADDR_W'(cursor_q - 1'b1);
					dest_d   = ADDR_W'(gap_q - 1'b1);
					cursor_d = cursor_q - 1'b1;
					gap_d    = gap_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			gap_q    <= CAP_POS;
			pend_s1  <= 1'b0;
		end else begin
			cursor_q <= cursor_d;
			gap_q    <= gap_d;
			pend_s1  <= ctl.move & step;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q  <= cmd;
			char_q <= char_in;
			opnd_q <= operand;
		end
		target_q <= target_d;
		ok_q     <= ok_d;
		rd_hit_q <= rd_hit_d;
		dest_s1  <= dest_d;
		if (ctl.ld_out) begin
			ok_o_q   <= ok_q;
			char_o_q <= rd_hit_q ? rdata_q : '0;
			cur_o_q  <= cursor_q;
			used_o_q <= used;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	assign ok         = ok_o_q;
	assign char_out   = char_o_q;
	assign cursor_pos = cur_o_q;
	assign used_len   = used_o_q;

endmodule

@@ rtl/gbte_ctrl.sv @@
// gbte_ctrl: sequencing state machine and result valid flag for the gap
// buffer engine; uses gbte_pkg
module gbte_ctrl import gbte_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  gbte_sts_t sts,
	output gbte_ctl_t ctl
);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_MOVE, S_DONE} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free   = !out_valid_q || !out_stall;
	assign in_stall   = state_q != S_IDLE;
	assign out_valid  = out_valid_q;
	assign ctl.latch  = in_valid && (state_q == S_IDLE);
	assign ctl.exec   = state_q == S_EXEC;
	assign ctl.move   = state_q == S_MOVE;
	assign ctl.ld_out = (state_q == S_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.ld_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_EXEC;
				S_EXEC: state_q <= sts.is_move ? S_MOVE : S_DONE;
				S_MOVE: if (sts.at_target) state_q <= S_DONE;
				S_DONE: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_EXEC)
		else $error("accepted beat did not start execution");
	a_exec_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC |=> state_q == S_MOVE || state_q == S_DONE)
		else $error("execute state left to wrong state");
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && out_valid_q && out_stall |=> state_q == S_DONE)
		else $error("result dropped while output stalled");
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ld_out |=> out_valid_q)
		else $error("loaded result not presented");
`endif

endmodule

@@ dv/gap_buffer_text_engine_unit_test.sv @@
// gap_buffer_text_engine_unit_test: self-checking bench for the gap buffer text engine
// random-paced command beats, result beats checked against an in-bench buffer model
// depends on gbte_pkg and gap_buffer_text_engine_unit
module gap_buffer_text_engine_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import gbte_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;
	localparam int IDLE_LIMIT = 5000;

	typedef struct packed {
		logic [CMD_W-1:0]  op;
		logic [CHAR_W-1:0] ch;
		logic [POS_W-1:0]  arg;
	} edit_beat_t;

	typedef struct packed {
		logic              ok;
		logic [CHAR_W-1:0] ch;
		logic [POS_W-1:0]  cursor;
		logic [POS_W-1:0]  used;
	} edit_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [CMD_W-1:0]  cmd = CMD_INSERT;
	logic [CHAR_W-1:0] char_in = '0;
	logic [POS_W-1:0]  operand = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              ok;
	logic [CHAR_W-1:0] char_out;
	logic [POS_W-1:0]  cursor_pos;
	logic [POS_W-1:0]  used_len;

	gap_buffer_text_engine_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.char_in(char_in),
		.operand(operand),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ok(ok),
		.char_out(char_out),
		.cursor_pos(cursor_pos),
		.used_len(used_len)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// buffer model: front part [0, caret), back part [gap_end, CAPACITY)
	logic [CHAR_W-1:0] text_mem [CAPACITY];
	int caret = 0;
	int gap_end = CAPACITY;

	edit_beat_t   pending_beats [$];
	edit_result_t expected_results [$];
	edit_beat_t   next_beat;
	edit_result_t predicted;
	edit_result_t awaited;

	int errors = 0;
	int op_count [8] = '{default: 0};
	int full_rejects = 0;
	int peak_len = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_cycle = 0;
	int stall_mode = 0;
	int idle_cycles = 0;

	function automatic void shift_left();
		if (caret > 0 && gap_end > 0) begin
			caret--;
			gap_end--;
			text_mem[gap_end] = text_mem[caret];
		end
	endfunction

	function automatic void shift_right();
		if (gap_end < CAPACITY && caret < CAPACITY) begin
			text_mem[caret] = text_mem[gap_end];
			caret++;
			gap_end++;
		end
	endfunction

	function automatic edit_result_t apply_edit(input edit_beat_t b);
		edit_result_t r;
		int len, back, arg, target, phys;
		len = caret + CAPACITY - gap_end;
		back = CAPACITY - gap_end;
		arg = int'(b.arg);
		r.ok = 1'b1;
		r.ch = '0;
		case (b.op)
			CMD_INSERT: begin
				if (caret >= gap_end) begin
					r.ok = 1'b0;
				end else begin
					text_mem[caret] = b.ch;
					caret++;
				end
			end
			CMD_LEFT: shift_left();
			CMD_RIGHT: shift_right();
			CMD_SETCUR: begin
				target = (arg > len) ? len : arg;
				while (caret < target) shift_right();
				while (caret > target) shift_left();
			end
			CMD_BKSP: caret -= (arg > caret) ? caret : arg;
			CMD_DEL: gap_end += (arg > back) ? back : arg;
			CMD_READ: begin
				if (arg < len) begin
					phys = (arg < caret) ? arg : arg + gap_end - caret;
					if (phys < CAPACITY) r.ch = text_mem[phys];
				end
			end
			default: ;
		endcase
		r.cursor = POS_W'(caret);
		r.used = POS_W'(caret + CAPACITY - gap_end);
		return r;
	endfunction

	// command side: bursts of beats with random gaps, the odd long unbroken run
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cmd <= CMD_INSERT;
			char_in <= '0;
			operand <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				predicted = apply_edit({cmd, char_in, operand});
				expected_results.push_back(predicted);
				op_count[cmd]++;
				if (!predicted.ok) full_rejects++;
				if (predicted.used > peak_len) peak_len = int'(predicted.used);
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_beats.size() > 0) begin
					next_beat = pending_beats.pop_front();
					cmd <= next_beat.op;
					char_in <= next_beat.ch;
					operand <= next_beat.arg;
					in_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else if ($urandom_range(0, 7) == 0) begin
						burst_left = $urandom_range(100, 300);
						gap_left = 0;
					end else begin
						burst_left = $urandom_range(0, 12);
						gap_left = $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result side: stall pattern redrawn at random from four modes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result beat arrived with nothing expected");
					errors++;
				end else begin
					awaited = expected_results.pop_front();
					if (ok !== awaited.ok) begin
						$error("ok: expected %0d, got %0d", awaited.ok, ok);
						errors++;
					end
					if (char_out !== awaited.ch) begin
						$error("char_out: expected %0h, got %0h", awaited.ch, char_out);
						errors++;
					end
					if (cursor_pos !== awaited.cursor) begin
						$error("cursor_pos: expected %0d, got %0d", awaited.cursor, cursor_pos);
						errors++;
					end
					if (used_len !== awaited.used) begin
						$error("used_len: expected %0d, got %0d", awaited.used, used_len);
						errors++;
					end
				end
			end
			stall_cycle++;
			if (stall_cycle % 256 == 0) stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= (stall_cycle % 8 < 3);
			endcase
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("gap_buffer_text_engine_unit_test: FAIL");
			$finish;
		end
	end

	function automatic void queue_beat(input logic [CMD_W-1:0] op, input logic [CHAR_W-1:0] ch,
			input int arg);
		pending_beats.push_back({op, ch, POS_W'(arg)});
	endfunction

	// wait until every beat has gone through and every result has been seen
	task automatic settle();
		while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic edit_chunk(input int ins_w);
		int len, pos, pick, lo, hi, arg;
		logic [CMD_W-1:0] op;
		len = caret + CAPACITY - gap_end;
		pos = caret;
		repeat (30) begin
			arg = $urandom_range(0, CAPACITY);
			pick = $urandom_range(0, 99);
			if (pick < ins_w) begin
				op = CMD_INSERT;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 12) op = CMD_LEFT;
				else if (pick < 24) op = CMD_RIGHT;
				else if (pick < 40) op = CMD_SETCUR;
				else if (pick < 54) op = CMD_BKSP;
				else if (pick < 68) op = CMD_DEL;
				else if (pick < 96) op = CMD_READ;
				else op = CMD_SPARE;
			end
			case (op)
				CMD_SETCUR: begin
					// mostly short hops round the cursor the chunk started at, the odd long move
					if ($urandom_range(0, 6) != 0) begin
						lo = (pos > 6) ? pos - 6 : 0;
						hi = (pos + 6 > CAPACITY) ? CAPACITY : pos + 6;
						arg = $urandom_range(lo, hi);
					end
				end
				CMD_BKSP, CMD_DEL: begin
					pick = $urandom_range(0, 19);
					if (pick < 16) arg = $urandom_range(0, 3);
					else if (pick < 19) arg = $urandom_range(0, 40);
				end
				CMD_READ: begin
					pick = $urandom_range(0, 19);
					if (pick < 15 && len > 0) arg = $urandom_range(0, len - 1);
					else if (pick < 18)
						arg = (len + 3 > CAPACITY) ? CAPACITY : $urandom_range(len, len + 3);
				end
				default: ;
			endcase
			queue_beat(op, CHAR_W'($urandom_range(0, 255)), arg);
		end
	endtask

	// fill to capacity, then poke at the full buffer from several cursor positions
	task automatic fill_up();
		int room;
		room = gap_end - caret;
		repeat (room)
			queue_beat(CMD_INSERT, CHAR_W'($urandom_range(0, 255)), $urandom_range(0, CAPACITY));
		queue_beat(CMD_INSERT, 8'h3c, 0);
		queue_beat(CMD_READ, 8'h00, CAPACITY - 1);
		queue_beat(CMD_READ, 8'h00, CAPACITY);
		queue_beat(CMD_LEFT, 8'h00, 0);
		queue_beat(CMD_INSERT, 8'hc3, 0);
		queue_beat(CMD_SETCUR, 8'h00, $urandom_range(0, CAPACITY));
		queue_beat(CMD_INSERT, 8'h81, 0);
		queue_beat(CMD_READ, 8'h00, $urandom_range(0, CAPACITY - 1));
		queue_beat(CMD_SETCUR, 8'h00, CAPACITY);
		queue_beat(CMD_RIGHT, 8'h00, 0);
		queue_beat(CMD_INSERT, 8'h18, 0);
	endtask

	task automatic empty_out();
		queue_beat(CMD_BKSP, 8'h00, CAPACITY);
		queue_beat(CMD_DEL, 8'h00, CAPACITY);
		queue_beat(CMD_READ, 8'h00, 0);
		queue_beat(CMD_LEFT, 8'h00, 0);
		queue_beat(CMD_RIGHT, 8'h00, 0);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// empty buffer edges
		queue_beat(CMD_READ, 8'h00, 0);
		queue_beat(CMD_LEFT, 8'h00, 0);
		queue_beat(CMD_RIGHT, 8'h00, 0);
		queue_beat(CMD_BKSP, 8'h00, 5);
		queue_beat(CMD_DEL, 8'h00, CAPACITY);
		queue_beat(CMD_SETCUR, 8'h00, CAPACITY);
		queue_beat(CMD_SPARE, 8'hff, CAPACITY);
		// short text, split by the gap
		queue_beat(CMD_INSERT, 8'h00, 0);
		queue_beat(CMD_INSERT, 8'hff, 0);
		queue_beat(CMD_INSERT, 8'ha5, 0);
		queue_beat(CMD_INSERT, 8'h5a, 0);
		queue_beat(CMD_LEFT, 8'h00, 0);
		queue_beat(CMD_LEFT, 8'h00, 0);
		queue_beat(CMD_READ, 8'h00, 0);
		queue_beat(CMD_READ, 8'h00, 3);
		queue_beat(CMD_READ, 8'h00, 4);
		queue_beat(CMD_READ, 8'h00, CAPACITY);
		queue_beat(CMD_RIGHT, 8'h00, 0);
		queue_beat(CMD_SETCUR, 8'h00, 0);
		queue_beat(CMD_SETCUR, 8'h00, CAPACITY);
		queue_beat(CMD_SETCUR, 8'h00, 1);
		queue_beat(CMD_BKSP, 8'h00, CAPACITY);
		queue_beat(CMD_DEL, 8'h00, CAPACITY);
		queue_beat(CMD_INSERT, 8'h7e, 0);
		queue_beat(CMD_READ, 8'h00, 0);
		settle();

		for (int k = 0; k < 12; k++) begin
			if (k == 6) fill_up();
			else if (k == 9) empty_out();
			else edit_chunk((k < 6) ? 70 : 40);
			settle();
		end
		repeat (20) @(posedge clk);

		$display("commands: insert %0d, left %0d, right %0d, set cursor %0d",
			op_count[CMD_INSERT], op_count[CMD_LEFT], op_count[CMD_RIGHT],
			op_count[CMD_SETCUR]);
		$display("  backspace %0d, delete %0d, read %0d, unused %0d",
			op_count[CMD_BKSP], op_count[CMD_DEL], op_count[CMD_READ], op_count[CMD_SPARE]);
		$display("inserts refused on a full buffer: %0d, longest text held: %0d bytes",
			full_rejects, peak_len);
		if (errors == 0)
			$display("gap_buffer_text_engine_unit_test: PASS");
		else
			$display("gap_buffer_text_engine_unit_test: FAIL");
		$finish;
	end

endmodule
